[src/four_class_priority_queue_stats_macros.svh]
// Assertion macros shared by the checker.
`ifndef FOUR_CLASS_PRIORITY_QUEUE_STATS_MACROS_SVH
`define FOUR_CLASS_PRIORITY_QUEUE_STATS_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define CPQS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off while reset is high.
`define CPQS_ASSERT_NEXT(label, clk, ante, cons, rst, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define CPQS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[src/cpqs_pkg.sv]
package cpqs_pkg;

   localparam int NUM_CLASSES = 4;
   localparam int CLASS_W     = 2;
   localparam int PCLASS_W    = 3;
   localparam int TIME_W      = 11;
   localparam int WAIT_W      = 12;
   localparam int COUNT_W     = 16;
   localparam int PEAK_W      = 9;
   localparam int PEAK_MAX    = 511;
   localparam int TUSER_W     = 2;
   localparam int IN_DATA_W   = 16;
   localparam int OUT_DATA_W  = 128;

   typedef enum logic [1:0] {
      OP_ARRIVE = 2'd0,
      OP_SERVE  = 2'd1,
      OP_STATUS = 2'd2,
      OP_REPORT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_SERVED = 2'd0,
      KIND_NONE   = 2'd1,
      KIND_STATUS = 2'd2,
      KIND_REPORT = 2'd3
   } kind_type;

   typedef logic [COUNT_W-1:0] count_type;

   // Request after queue update, waiting for the popped arrival time.
   typedef struct packed {
      kind_type                          kind;
      logic [CLASS_W-1:0]                served_class;
      logic [TIME_W-1:0]                 req_time;
      count_type [NUM_CLASSES-1:0]       counts;
      count_type                         served_total;
      logic [PEAK_W-1:0]                 peak;
   } stage_type;

   // Finished response as it leaves on the result channel.
   typedef struct packed {
      kind_type                          kind;
      logic [CLASS_W-1:0]                served_class;
      logic [WAIT_W-1:0]                 wait_minutes;
      logic [TIME_W-1:0]                 echo_time;
      count_type [NUM_CLASSES-1:0]       counts;
      count_type                         served_total;
      logic [PEAK_W-1:0]                 peak;
      logic [TIME_W-1:0]                 max_wait;
   } result_type;

endpackage

[src/cpqs_arrival_mem.sv]
module cpqs_arrival_mem
   import cpqs_pkg::*;
#(
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [TIME_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [TIME_W-1:0] rd_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [TIME_W-1:0] mem [0:DEPTH-1];
   logic [TIME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/cpqs_queue_ctrl.sv]
module cpqs_queue_ctrl
   import cpqs_pkg::*;
#(
   parameter  int QUEUE_DEPTH  = 64,
   parameter  int COUNTER_BITS = 16,
   localparam int PTR_W        = $clog2(QUEUE_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  op_type               op,
   input  logic [PCLASS_W-1:0]  pclass,
   input  logic [TIME_W-1:0]    req_time,
   output logic                 mem_wr_en,
   output logic [PTR_W+1:0]     mem_wr_addr,
   output logic [TIME_W-1:0]    mem_wr_data,
   output logic                 mem_rd_en,
   output logic [PTR_W+1:0]     mem_rd_addr,
   output stage_type            stage_in
);

   localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = PTR_W + 1;
   localparam int TOT_W = (LEN_W + 2 > PEAK_W + 1) ? LEN_W + 2 : PEAK_W + 1;
   localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);
   localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   logic [NUM_CLASSES-1:0][PTR_W-1:0]        head_ff, head_in;
   logic [NUM_CLASSES-1:0][LEN_W-1:0]        len_ff, len_in;
   logic [NUM_CLASSES-1:0][COUNTER_BITS-1:0] served_ff, served_in;
   logic [COUNTER_BITS-1:0]                  total_ff, total_in;
   logic [PEAK_W-1:0]                        peak_ff, peak_in;

   logic [CLASS_W-1:0] cls;
   logic [CLASS_W-1:0] pop_cls;
   logic               pop_found;
   logic [PTR_W-1:0]   sel_head;
   logic [LEN_W-1:0]   sel_len;
   logic [PTR_W-1:0]   pop_head;
   logic [SUM_W-1:0]   tail_sum;
   logic [SUM_W-1:0]   tail_pos;
   logic               arrive_ok;
   logic               arrive_go;
   logic               serve_go;
   logic [TOT_W-1:0]   occupancy;
   logic [PEAK_W-1:0]  occupancy_sat;

   function automatic count_type sat16(input logic [COUNTER_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h0000_FFFF) ? 16'hFFFF : w[COUNT_W-1:0];
   endfunction

   function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   assign cls = pclass[CLASS_W-1:0];

   // Lowest-numbered class with anything queued (class 0 has top priority).
   always_comb begin
      pop_found = 1'b0;
      pop_cls   = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (len_ff[c] != '0) begin
            pop_found = 1'b1;
            pop_cls   = CLASS_W'(c);
         end
      end
   end

   always_comb begin
      sel_head = '0;
      sel_len  = '0;
      pop_head = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (CLASS_W'(c) == cls) begin
            sel_head = head_ff[c];
            sel_len  = len_ff[c];
         end
         if (CLASS_W'(c) == pop_cls) begin
            pop_head = head_ff[c];
         end
      end
   end

   // Tail slot: head plus length, wrapped at the queue depth.
   assign tail_sum  = SUM_W'(sel_head) + SUM_W'(sel_len);
   assign tail_pos  = (tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum;
   assign arrive_ok = !pclass[PCLASS_W-1] && (sel_len != FULL_LEN);
   assign arrive_go = accept && (op == OP_ARRIVE) && arrive_ok;
   assign serve_go  = accept && (op == OP_SERVE) && pop_found;

   assign mem_wr_en   = arrive_go;
   assign mem_wr_addr = {cls, tail_pos[PTR_W-1:0]};
   assign mem_wr_data = req_time;
   assign mem_rd_en   = serve_go;
   assign mem_rd_addr = {pop_cls, pop_head};

   always_comb begin
      head_in   = head_ff;
      len_in    = len_ff;
      served_in = served_ff;
      total_in  = total_ff;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (arrive_go && (CLASS_W'(c) == cls)) begin
            len_in[c] = len_ff[c] + 1'b1;
         end
         if (serve_go && (CLASS_W'(c) == pop_cls)) begin
            head_in[c]   = (head_ff[c] == LAST_PTR) ? '0 : head_ff[c] + 1'b1;
            len_in[c]    = len_ff[c] - 1'b1;
            served_in[c] = sat_inc(served_ff[c]);
         end
      end
      if (serve_go) begin
         total_in = sat_inc(total_ff);
      end
   end

   // Peak follows every arrive request, dropped or not.
   always_comb begin
      occupancy = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         occupancy = occupancy + TOT_W'(len_in[c]);
      end
      occupancy_sat = (occupancy > TOT_W'(PEAK_MAX)) ? PEAK_W'(PEAK_MAX)
                                                     : occupancy[PEAK_W-1:0];
      peak_in = peak_ff;
      if (accept && (op == OP_ARRIVE) && (occupancy_sat > peak_ff)) begin
         peak_in = occupancy_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         len_ff    <= '0;
         served_ff <= '0;
         total_ff  <= '0;
         peak_ff   <= '0;
      end else begin
         head_ff   <= head_in;
         len_ff    <= len_in;
         served_ff <= served_in;
         total_ff  <= total_in;
         peak_ff   <= peak_in;
      end
   end

   // Stage record built from the state before this request's update.
   always_comb begin
      stage_in              = '0;
      stage_in.req_time     = req_time;
      unique case (op)
         OP_SERVE: begin
            stage_in.kind         = pop_found ? KIND_SERVED : KIND_NONE;
            stage_in.served_class = pop_found ? pop_cls : '0;
         end
         OP_STATUS: begin
            stage_in.kind = KIND_STATUS;
            for (int c = 0; c < NUM_CLASSES; c++) begin
               stage_in.counts[c] = COUNT_W'(len_ff[c]);
            end
            stage_in.served_total = sat16(total_ff);
         end
         OP_REPORT: begin
            stage_in.kind = KIND_REPORT;
            for (int c = 0; c < NUM_CLASSES; c++) begin
               stage_in.counts[c] = sat16(served_ff[c]);
            end
            stage_in.served_total = sat16(total_ff);
            stage_in.peak         = peak_ff;
         end
         OP_ARRIVE: begin
            stage_in.kind = KIND_SERVED;
         end
         default: begin
            stage_in.kind = KIND_SERVED;
         end
      endcase
   end

endmodule

[src/cpqs_resp.sv]
module cpqs_resp
   import cpqs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  op_type            req_op,
   output logic              req_tready,
   output logic              accept,
   input  stage_type         stage_in,
   input  logic [TIME_W-1:0] rd_data,
   input  logic              rsp_tready,
   output logic              rsp_valid,
   output result_type        rsp
);

   logic              stage_valid_ff, stage_valid_in;
   stage_type         stage_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;
   logic [TIME_W-1:0] longest_ff, longest_in;
   logic              advance;
   logic              stage_load;
   logic [WAIT_W-1:0] wait_val;

   assign advance    = stage_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign stage_load = accept && (req_op != OP_ARRIVE);

   assign stage_valid_in = stage_load || (stage_valid_ff && !advance);
   assign out_valid_in   = advance || (out_valid_ff && !rsp_tready);

   assign wait_val = {1'b0, stage_ff.req_time} - {1'b0, rd_data};

   always_comb begin
      longest_in = longest_ff;
      if (advance && (stage_ff.kind == KIND_SERVED) && !wait_val[WAIT_W-1] &&
          (wait_val[TIME_W-1:0] > longest_ff)) begin
         longest_in = wait_val[TIME_W-1:0];
      end
   end

   always_comb begin
      out_in              = '0;
      out_in.kind         = stage_ff.kind;
      out_in.served_class = stage_ff.served_class;
      out_in.counts       = stage_ff.counts;
      out_in.served_total = stage_ff.served_total;
      out_in.peak         = stage_ff.peak;
      unique case (stage_ff.kind)
         KIND_SERVED: out_in.wait_minutes = wait_val;
         KIND_NONE:   out_in.echo_time    = stage_ff.req_time;
         KIND_REPORT: out_in.max_wait     = longest_ff;
         KIND_STATUS: out_in.max_wait     = '0;
         default:     out_in.max_wait     = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         longest_ff     <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         longest_ff     <= longest_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load) begin
         stage_ff <= stage_in;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

[src/four_class_priority_queue_stats.sv]
// Four-class strict priority queue with service statistics.
//
// Request channel (req_*): tuser carries the operation (arrive, serve,
// status, report); tdata carries the class and the time of day in minutes.
// Arrive requests queue a time in their class FIFO and give no response.
// Serve, status and report requests each give exactly one response on the
// rsp_* channel, whose tuser carries the result kind.
//
// A response passes the stage register, then the response register,
// before it shows on rsp_tvalid. Throughput: one request per cycle while
// rsp_tready stays high. The popped arrival time comes out of a memory
// with a registered read port; the wait subtraction and the maximum-wait
// update sit after that register.
// Reset clears all queue pointers, lengths, counters and both pipeline
// valids; the arrival memory is not cleared and needs no clearing pass.
// When the receiver stalls, the response register holds and the next
// response waits in the stage register; req_tready drops only when both
// are full and rsp_tready is low.
module four_class_priority_queue_stats
   import cpqs_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 64,
   parameter int COUNTER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] priority_class, [13:3] time_minutes, [15:14] zero
   input  logic [IN_DATA_W-1:0]  req_tdata,
   // [1:0] operation
   input  logic [TUSER_W-1:0]    req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] served_class, [13:2] wait_minutes, [24:14] echo_time,
   // [40:25] count_class0, [56:41] count_class1, [72:57] count_class2,
   // [88:73] count_class3, [104:89] served_total, [113:105] peak_occupancy,
   // [124:114] max_wait, [127:125] zero
   output logic [OUT_DATA_W-1:0] rsp_tdata,
   // [1:0] result_kind
   output logic [TUSER_W-1:0]    rsp_tuser
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int ADDR_W = PTR_W + CLASS_W;

   op_type              req_op;
   logic [PCLASS_W-1:0] req_class;
   logic [TIME_W-1:0]   req_time;
   logic                accept;
   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   logic [TIME_W-1:0]   mem_wr_data;
   logic                mem_rd_en;
   logic [ADDR_W-1:0]   mem_rd_addr;
   logic [TIME_W-1:0]   mem_rd_data;
   stage_type           stage_in;
   result_type          rsp;

   // Unpack the request.
   assign req_op    = op_type'(req_tuser);
   assign req_class = req_tdata[PCLASS_W-1:0];
   assign req_time  = req_tdata[PCLASS_W +: TIME_W];

   // Queue pointers, counters and pop selection; updates at request accept.
   cpqs_queue_ctrl #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_queue_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (req_op),
      .pclass      (req_class),
      .req_time    (req_time),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .stage_in    (stage_in)
   );

   // Arrival times, one region of QUEUE_DEPTH slots per class.
   cpqs_arrival_mem #(
      .ADDR_W (ADDR_W)
   ) u_arrival_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Stage and response registers, wait and maximum-wait tracking.
   cpqs_resp u_resp (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_op),
      .req_tready (req_tready),
      .accept     (accept),
      .stage_in   (stage_in),
      .rd_data    (mem_rd_data),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp        (rsp)
   );

   // Pack the response, first field in the lowest bits.
   assign rsp_tuser = rsp.kind;
   assign rsp_tdata = {3'b000,
                       rsp.max_wait,
                       rsp.peak,
                       rsp.served_total,
                       rsp.counts[3],
                       rsp.counts[2],
                       rsp.counts[1],
                       rsp.counts[0],
                       rsp.echo_time,
                       rsp.wait_minutes,
                       rsp.served_class};

endmodule

[src/cpqs_checker.sv]
`include "four_class_priority_queue_stats_macros.svh"

module cpqs_checker
   import cpqs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [OUT_DATA_W-1:0] rsp_tdata,
   input logic [TUSER_W-1:0]    rsp_tuser
);

   `CPQS_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid && req_tready, "response or backpressure right after reset")

   `CPQS_ASSERT_IMPLIES(a_ready_only_when_full, clock, reset, !req_tready, rsp_tvalid, "request stalled with no response pending")

   `CPQS_ASSERT_NEXT(a_rsp_hold, clock, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), reset, "stalled response changed")

   `CPQS_ASSERT_IMPLIES(a_status_fields, clock, reset, rsp_tvalid && (rsp_tuser == KIND_STATUS), (rsp_tdata[124:105] == '0) && (rsp_tdata[24:0] == '0), "status response with serve or report fields set")

   `CPQS_ASSERT_IMPLIES(a_none_fields, clock, reset, rsp_tvalid && (rsp_tuser == KIND_NONE), (rsp_tdata[13:0] == '0) && (rsp_tdata[127:25] == '0), "none-waiting response with extra fields set")

endmodule

bind four_class_priority_queue_stats cpqs_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[tb/tb_four_class_priority_queue_stats.sv]
module tb_four_class_priority_queue_stats;
   import cpqs_pkg::*;

   localparam int QUEUE_SLOTS  = 64;    // entries per class FIFO in the block
   localparam int ITEM_TARGET  = 1750;  // random requests that do real work
   localparam int HOLD_SPAN    = 120;   // cycles of a long receiver hold-off
   localparam int SETTLE_SPAN  = 8;     // watch for stray responses at the end

   typedef enum int {PHASE_FILL, PHASE_PRESSURE, PHASE_DRAIN, PHASE_MIXED} phase_type;
   typedef enum int {READY_ALWAYS, READY_COIN, READY_RARE_STALL, READY_RHYTHM}
      ready_pattern_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata  = '0;
   logic [TUSER_W-1:0]    req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic [TUSER_W-1:0]    rsp_tuser;

   // Bumped by the stimulus side to ask the receiver for one long hold-off.
   int hold_requests = 0;

   four_class_priority_queue_stats dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Mirror of the queue set and its statistics. Every accepted request is
   // applied here in order; serve, status and report requests leave one
   // expected response that the result channel must match in order.
   class service_ledger;
      logic [TIME_W-1:0] arrivals [NUM_CLASSES][QUEUE_SLOTS];
      int unsigned       head [NUM_CLASSES];
      int unsigned       depth_now [NUM_CLASSES];
      count_type         served_by_class [NUM_CLASSES];
      count_type         served_sum;
      logic [PEAK_W-1:0] peak_seen;
      logic [TIME_W-1:0] longest;
      result_type        outstanding [$];
      int                mismatches;

      function new();
         foreach (head[c]) begin
            head[c]            = 0;
            depth_now[c]       = 0;
            served_by_class[c] = '0;
         end
         served_sum = '0;
         peak_seen  = '0;
         longest    = '0;
         mismatches = 0;
      endfunction

      function void note_request(op_type op, logic [PCLASS_W-1:0] cls,
                                 logic [TIME_W-1:0] tm);
         result_type r;
         int         total;
         int         pick;
         int         w;
         r = '0;
         case (op)
            OP_ARRIVE: begin
               // Drop on a full class or an invalid class; the peak still updates.
               if (cls < NUM_CLASSES && depth_now[cls[1:0]] < QUEUE_SLOTS) begin
                  arrivals[cls[1:0]][(head[cls[1:0]] + depth_now[cls[1:0]]) % QUEUE_SLOTS]
                     = tm;
                  depth_now[cls[1:0]]++;
               end
               total = 0;
               foreach (depth_now[c]) total += depth_now[c];
               if (total > PEAK_MAX) total = PEAK_MAX;
               if (total > int'(peak_seen)) peak_seen = total[PEAK_W-1:0];
               return;
            end
            OP_SERVE: begin
               pick = -1;
               for (int c = NUM_CLASSES - 1; c >= 0; c--)
                  if (depth_now[c] != 0) pick = c;
               if (pick < 0) begin
                  r.kind      = KIND_NONE;
                  r.echo_time = tm;
               end else begin
                  w = int'(tm) - int'(arrivals[pick][head[pick]]);
                  head[pick] = (head[pick] + 1) % QUEUE_SLOTS;
                  depth_now[pick]--;
                  if (served_by_class[pick] != '1) served_by_class[pick]++;
                  if (served_sum != '1) served_sum++;
                  if (w > int'(longest)) longest = w[TIME_W-1:0];
                  r.kind         = KIND_SERVED;
                  r.served_class = pick[CLASS_W-1:0];
                  r.wait_minutes = w[WAIT_W-1:0];
               end
            end
            OP_STATUS: begin
               r.kind = KIND_STATUS;
               foreach (depth_now[c]) r.counts[c] = depth_now[c][COUNT_W-1:0];
               r.served_total = served_sum;
            end
            default: begin
               r.kind = KIND_REPORT;
               foreach (served_by_class[c]) r.counts[c] = served_by_class[c];
               r.served_total = served_sum;
               r.peak         = peak_seen;
               r.max_wait     = longest;
            end
         endcase
         outstanding.push_back(r);
      endfunction

      function void compare(string field, int want, int got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(logic [TUSER_W-1:0] kind,
                                   logic [OUT_DATA_W-1:0] data);
         result_type e;
         if (outstanding.size() == 0) begin
            $error("response of kind %0d with no request outstanding", kind);
            mismatches++;
            return;
         end
         e = outstanding.pop_front();
         compare("result_kind", int'(e.kind), int'(kind));
         compare("served_class", int'(e.served_class), int'(data[1:0]));
         compare("wait_minutes", int'($signed(e.wait_minutes)), int'($signed(data[13:2])));
         compare("echo_time", int'(e.echo_time), int'(data[24:14]));
         for (int c = 0; c < NUM_CLASSES; c++)
            compare($sformatf("count_class%0d", c), int'(e.counts[c]),
                    int'(data[25 + COUNT_W*c +: COUNT_W]));
         compare("served_total", int'(e.served_total), int'(data[104:89]));
         compare("peak_occupancy", int'(e.peak), int'(data[113:105]));
         compare("max_wait", int'(e.max_wait), int'(data[124:114]));
      endfunction
   endclass

   service_ledger ledger = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one request and hold it until the block takes it.
   task automatic offer(op_type op, logic [PCLASS_W-1:0] cls, logic [TIME_W-1:0] tm);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, tm, cls};
      do @(posedge clock); while (!req_tready);
      ledger.note_request(op, cls, tm);
   endtask

   // Drop valid for a gap, with junk on the bus that must be ignored.
   task automatic rest(int cycles);
      req_tvalid <= 1'b0;
      req_tuser  <= TUSER_W'($urandom_range(0, 3));
      req_tdata  <= IN_DATA_W'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // Receiver: check each accepted response, then pick the next ready value.
   // A long hold-off, when asked for, overrides the running stall pattern.
   initial begin : receiver
      int                hold_left;
      int                holds_done;
      int                mode_left;
      int unsigned       beat;
      ready_pattern_type pattern;
      hold_left  = 0;
      holds_done = 0;
      mode_left  = 0;
      beat       = 0;
      pattern    = READY_ALWAYS;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            ledger.check_response(rsp_tuser, rsp_tdata);
         beat++;
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            hold_left  = HOLD_SPAN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               pattern   = ready_pattern_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (pattern)
               READY_ALWAYS:     rsp_tready <= 1'b1;
               READY_COIN:       rsp_tready <= 1'($urandom_range(0, 1));
               READY_RARE_STALL: rsp_tready <= ($urandom_range(0, 7) != 0);
               default:          rsp_tready <= (beat % 5 < 2);
            endcase
         end
      end
   end

   // Stimulus: directed corner cases, then phases that fill, stall, drain and
   // mix the queues so that full classes and empty serves both come up often.
   initial begin : stimulus
      int        sent;
      int        phase_idx;
      int        phase_len;
      int        burst_left;
      int        gap;
      int        roll;
      int        arrive_lim;
      int        serve_lim;
      int        status_lim;
      int        focus;
      int        now;
      phase_type phase;
      op_type    op;
      logic [PCLASS_W-1:0] cls;
      logic [TIME_W-1:0]   tm;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty queue set: status, and serves that find nobody waiting.
      offer(OP_STATUS, 3'd0, 11'd0);
      offer(OP_SERVE,  3'd0, 11'd1439);
      offer(OP_SERVE,  3'd5, 11'd0);
      // One arrival per class, class 3 first, plus invalid classes and a second class 0.
      offer(OP_ARRIVE, 3'd3, 11'd0);
      offer(OP_ARRIVE, 3'd2, 11'd100);
      offer(OP_ARRIVE, 3'd1, 11'd1439);
      offer(OP_ARRIVE, 3'd0, 11'd720);
      offer(OP_ARRIVE, 3'd4, 11'd1024);
      offer(OP_ARRIVE, 3'd7, 11'd1023);
      offer(OP_ARRIVE, 3'd0, 11'd5);
      offer(OP_STATUS, 3'd6, 11'd512);
      // Serve in strict priority order: positive, negative and extreme waits.
      offer(OP_SERVE,  3'd0, 11'd725);
      offer(OP_SERVE,  3'd0, 11'd0);
      offer(OP_SERVE,  3'd0, 11'd0);
      offer(OP_SERVE,  3'd0, 11'd1439);
      offer(OP_SERVE,  3'd0, 11'd1439);
      offer(OP_SERVE,  3'd0, 11'd300);
      offer(OP_REPORT, 3'd0, 11'd0);
      // State survives a report.
      offer(OP_ARRIVE, 3'd1, 11'd600);
      offer(OP_STATUS, 3'd0, 11'd0);
      rest(3);

      sent      = 0;
      phase_idx = 0;
      now       = 480;
      while (sent < ITEM_TARGET) begin
         phase = phase_type'(phase_idx % 4);
         phase_idx++;
         focus = $urandom_range(0, NUM_CLASSES - 1);
         case (phase)
            PHASE_FILL: begin
               phase_len = $urandom_range(80, 160);
               arrive_lim = 85; serve_lim = 93; status_lim = 98;
            end
            PHASE_PRESSURE: begin
               phase_len = $urandom_range(30, 50);
               arrive_lim = 30; serve_lim = 75; status_lim = 92;
               // Ask for a long receiver hold-off while requests keep coming.
               hold_requests <= hold_requests + 1;
            end
            PHASE_DRAIN: begin
               phase_len = $urandom_range(60, 180);
               arrive_lim = 12; serve_lim = 88; status_lim = 96;
            end
            default: begin
               phase_len = $urandom_range(40, 120);
               arrive_lim = 45; serve_lim = 85; status_lim = 95;
            end
         endcase
         burst_left = $urandom_range(1, 24);
         for (int k = 0; k < phase_len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < arrive_lim)      op = OP_ARRIVE;
            else if (roll < serve_lim)  op = OP_SERVE;
            else if (roll < status_lim) op = OP_STATUS;
            else                        op = OP_REPORT;

            roll = $urandom_range(0, 99);
            if (op == OP_ARRIVE && roll < 6)
               cls = PCLASS_W'($urandom_range(NUM_CLASSES, 7));
            else if (op == OP_ARRIVE && phase == PHASE_FILL && roll < 80)
               cls = PCLASS_W'(focus);
            else if (op == OP_ARRIVE)
               cls = PCLASS_W'($urandom_range(0, NUM_CLASSES - 1));
            else
               cls = PCLASS_W'($urandom_range(0, 7));

            // Mostly a running time of day; sometimes extremes or a jump back.
            now  = (now + $urandom_range(0, 3)) % 1440;
            roll = $urandom_range(0, 99);
            if (roll < 75)      tm = TIME_W'(now);
            else if (roll < 80) tm = '0;
            else if (roll < 85) tm = TIME_W'(1439);
            else                tm = TIME_W'($urandom_range(0, 1439));

            offer(op, cls, tm);
            if (!(op == OP_ARRIVE && cls >= NUM_CLASSES)) sent++;

            // Bursts with gaps in fill and drain; back to back elsewhere.
            if (phase == PHASE_FILL || phase == PHASE_DRAIN) begin
               burst_left--;
               if (burst_left == 0) begin
                  gap = $urandom_range(0, 12);
                  if (gap > 0) rest(gap);
                  burst_left = $urandom_range(1, 24);
               end
            end
         end
      end
      rest(1);

      // Wait out every outstanding response, then watch for strays.
      while (ledger.outstanding.size() != 0) @(posedge clock);
      repeat (SETTLE_SPAN) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.outstanding.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/cpqs_pkg.sv
src/cpqs_arrival_mem.sv
src/cpqs_queue_ctrl.sv
src/cpqs_resp.sv
src/four_class_priority_queue_stats.sv
src/cpqs_checker.sv
tb/tb_four_class_priority_queue_stats.sv
